FILE: rtl/core/hrsp_pkg.sv
`default_nettype none
package hrsp_pkg;

    localparam int RecBytes = 22;
    localparam int IdxW     = 5;
    localparam int CfgIdxW  = 2;

    typedef logic [RecBytes-1:0][7:0] rec_t;

    typedef enum logic [CfgIdxW-1:0] {
        CfgCoincMode = 2'd0,
        CfgFirstCode = 2'd1,
        CfgNextCode  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        StOk           = 3'd0,
        StZeroAmp      = 3'd1,
        StBadHeader    = 3'd2,
        StFrameChanged = 3'd3,
        StSeqBackwards = 3'd4
    } status_t;

    typedef struct packed {
        logic       coinc_mode;
        logic [7:0] first_code;
        logic [7:0] next_code;
    } cfg_t;

    typedef struct packed {
        logic [31:0] prev_seq;
        logic [7:0]  prev_frame;
        logic [31:0] prev_sync;
        logic [15:0] roll;
        logic [15:0] ref_sync;
        logic        seen;
    } track_t;

    typedef struct packed {
        logic        lead_hit;
        logic [15:0] target_id;
        logic [7:0]  die_number;
        logic [31:0] seq_number;
        logic [7:0]  frame_number;
        logic [31:0] relative_sync;
        logic [31:0] time_stamp;
        logic [15:0] cell_count_a;
        logic [15:0] cell_count_b;
        logic [15:0] cell_count_c;
        logic [15:0] cell_count_d;
        status_t     status;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/hit_record_stream_parser_unit.sv
// hit record stream parser
// in channel: one stream byte per beat on raw_byte (in_valid / in_stall).
// a record is 22 little-endian data bytes, preceded by one header byte when
// coincidence_mode is set (23 bytes per record).
// out channel: one beat per finished record with the decoded fields,
// lead_hit, relative_sync and status (out_valid / out_stall).
// cfg channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high; write only while no record is in progress.
// throughput: one byte per cycle while in_stall is low.
// the last byte of a record sets a pending flag; once the output is free the
// completed record is decoded into the result register and out_valid rises.
// in_stall rises only when a completed record waits while the previous result
// is still stalled at the output; otherwise bytes flow freely.
// an error status (bad header, frame changed, sequence backwards) halts the
// block: bytes are still taken but dropped, and no result follows until reset.
// reset clears the byte count, tracking state, halt flag and output valid,
// and loads the register defaults (plain mode, header codes 1 and 2).
`default_nettype none
module hit_record_stream_parser_unit (
    input  var logic                          clk,
    input  var logic                          rst_n,
    input  var logic                          in_valid,
    output var logic                          in_stall,
    input  var logic [7:0]                    raw_byte,
    output var logic                          out_valid,
    input  var logic                          out_stall,
    output var logic                          lead_hit,
    output var logic [15:0]                   target_id,
    output var logic [7:0]                    die_number,
    output var logic [31:0]                   seq_number,
    output var logic [7:0]                    frame_number,
    output var logic [31:0]                   relative_sync,
    output var logic [31:0]                   time_stamp,
    output var logic [15:0]                   cell_count_a,
    output var logic [15:0]                   cell_count_b,
    output var logic [15:0]                   cell_count_c,
    output var logic [15:0]                   cell_count_d,
    output var logic [2:0]                    status,
    input  var logic                          cfg_valid,
    output var logic                          cfg_ready,
    input  var logic [hrsp_pkg::CfgIdxW-1:0]  cfg_index,
    input  var logic [7:0]                    cfg_data
);
    import hrsp_pkg::*;

    cfg_t              cfg_reg;
    rec_t              rec_reg;
    logic [7:0]        header_reg;
    logic [IdxW-1:0]   idx_reg;
    logic [IdxW-1:0]   idx_next;
    logic              pend_reg;
    logic              pend_next;
    logic              halted_reg;
    logic              halted_next;
    track_t            track_reg;
    track_t            track_next;
    result_t           res_reg;
    result_t           res_dec;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              dec_error;
    logic              in_fire;
    logic              take;
    logic              fire;
    logic              last;
    logic              wr_en;
    logic [IdxW-1:0]   wr_idx;

    assign cfg_ready = 1'b1;

    hrsp_decode u_decode (
        .rec        (rec_reg),
        .header     (header_reg),
        .cfg        (cfg_reg),
        .track      (track_reg),
        .res        (res_dec),
        .track_next (track_next),
        .error      (dec_error)
    );

    always_comb
    begin
        fire     = pend_reg && (!out_valid_reg || !out_stall);
        in_stall = pend_reg && !fire;
        in_fire  = in_valid && !in_stall;
        take     = in_fire && !halted_reg;

        if (cfg_reg.coinc_mode)
        begin
            wr_idx = idx_reg - IdxW'(1);
            wr_en  = (idx_reg != '0) && (wr_idx < IdxW'(RecBytes));
            last   = idx_reg >= IdxW'(RecBytes);
        end
        else
        begin
            wr_idx = idx_reg;
            wr_en  = idx_reg < IdxW'(RecBytes);
            last   = idx_reg >= IdxW'(RecBytes - 1);
        end

        idx_next = idx_reg;
        if (take)
            idx_next = last ? '0 : idx_reg + IdxW'(1);

        pend_next = pend_reg;
        if (fire)
            pend_next = 1'b0;
        if (take && last)
            pend_next = 1'b1;

        halted_next = halted_reg || (fire && dec_error);

        if (fire)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coinc_mode <= 1'b0;
            cfg_reg.first_code <= 8'd1;
            cfg_reg.next_code  <= 8'd2;
            idx_reg            <= '0;
            pend_reg           <= 1'b0;
            halted_reg         <= 1'b0;
            track_reg          <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CfgCoincMode: cfg_reg.coinc_mode <= cfg_data[0];
                    CfgFirstCode: cfg_reg.first_code <= cfg_data;
                    CfgNextCode:  cfg_reg.next_code  <= cfg_data;
                    default:      ;
                endcase
            end
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
            if (fire && !dec_error)
                track_reg <= track_next;
        end
    end

    // record bytes and result payload carry no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (cfg_reg.coinc_mode && idx_reg == '0)
                header_reg <= raw_byte;
            else if (wr_en)
                rec_reg[wr_idx] <= raw_byte;
        end
        if (fire)
            res_reg <= res_dec;
    end

    assign out_valid      = out_valid_reg;
    assign lead_hit       = res_reg.lead_hit;
    assign target_id      = res_reg.target_id;
    assign die_number     = res_reg.die_number;
    assign seq_number     = res_reg.seq_number;
    assign frame_number   = res_reg.frame_number;
    assign relative_sync  = res_reg.relative_sync;
    assign time_stamp     = res_reg.time_stamp;
    assign cell_count_a   = res_reg.cell_count_a;
    assign cell_count_b   = res_reg.cell_count_b;
    assign cell_count_c   = res_reg.cell_count_c;
    assign cell_count_d   = res_reg.cell_count_d;
    assign status         = res_reg.status;

endmodule
`default_nettype wire

FILE: rtl/core/hrsp_decode.sv
`default_nettype none
module hrsp_decode (
    input  var hrsp_pkg::rec_t    rec,
    input  var logic [7:0]        header,
    input  var hrsp_pkg::cfg_t    cfg,
    input  var hrsp_pkg::track_t  track,
    output var hrsp_pkg::result_t res,
    output var hrsp_pkg::track_t  track_next,
    output var logic              error
);
    import hrsp_pkg::*;

    logic [31:0] seq;
    logic [7:0]  frame;
    logic [15:0] sync16;
    logic [31:0] pseq;
    logic [7:0]  pframe;
    logic [31:0] psync;
    logic [15:0] roll;
    logic [15:0] roll_inc;
    logic [15:0] ref_sync;
    logic [31:0] ext;
    logic [31:0] ext_up;
    logic [31:0] rel_a;
    logic [31:0] rel_b;
    logic        wrap;
    logic        bad_hdr;
    logic        frm_chg;
    logic        seq_back;
    logic        zero_amp;
    logic        first;

    always_comb
    begin
        seq    = {rec[3], rec[2], rec[1], rec[0]};
        frame  = rec[4];
        sync16 = {rec[6], rec[5]};

        // first record after reset tracks against itself
        pseq     = track.seen ? track.prev_seq   : seq;
        pframe   = track.seen ? track.prev_frame : frame;
        psync    = track.seen ? track.prev_sync  : {16'd0, sync16};
        roll     = track.seen ? track.roll       : 16'd0;
        ref_sync = track.seen ? track.ref_sync   : sync16;

        bad_hdr  = cfg.coinc_mode && (header != cfg.first_code)
                   && (header != cfg.next_code);
        frm_chg  = (seq == pseq) && (frame != pframe);
        seq_back = seq < pseq;
        error    = bad_hdr || frm_chg || seq_back;

        roll_inc = roll + 16'd1;
        ext      = {roll, sync16};
        ext_up   = {roll_inc, sync16};
        wrap     = ext < psync;
        rel_a    = ext - {16'd0, ref_sync} + 32'd1;
        rel_b    = ext_up - {16'd0, ref_sync} + 32'd1;

        zero_amp = ({rec[15], rec[14]} == 16'd0) && ({rec[17], rec[16]} == 16'd0)
                   && ({rec[19], rec[18]} == 16'd0) && ({rec[21], rec[20]} == 16'd0);

        if (cfg.coinc_mode)
            first = (header == cfg.first_code) || !track.seen;
        else
            first = (seq != pseq) || !track.seen;

        res.lead_hit       = first && !error;
        res.target_id      = {rec[8], rec[7]};
        res.die_number     = rec[9];
        res.seq_number     = seq;
        res.frame_number   = frame;
        res.relative_sync  = error ? 32'd0 : (wrap ? rel_b : rel_a);
        res.time_stamp     = {rec[13], rec[12], rec[11], rec[10]};
        res.cell_count_a   = {rec[15], rec[14]};
        res.cell_count_b   = {rec[17], rec[16]};
        res.cell_count_c   = {rec[19], rec[18]};
        res.cell_count_d   = {rec[21], rec[20]};

        if (bad_hdr)
            res.status = StBadHeader;
        else if (frm_chg)
            res.status = StFrameChanged;
        else if (seq_back)
            res.status = StSeqBackwards;
        else if (zero_amp)
            res.status = StZeroAmp;
        else
            res.status = StOk;

        track_next.prev_seq   = seq;
        track_next.prev_frame = frame;
        track_next.prev_sync  = wrap ? ext_up : ext;
        track_next.roll       = wrap ? roll_inc : roll;
        track_next.ref_sync   = ref_sync;
        track_next.seen       = 1'b1;
    end

endmodule
`default_nettype wire

FILE: rtl/core/hrsp_checker.sv
`default_nettype none
module hrsp_checker (
    input  var logic        clk,
    input  var logic        rst_n,
    input  var logic        out_valid,
    input  var logic        out_stall,
    input  var logic        lead_hit,
    input  var logic [31:0] relative_sync,
    input  var logic [2:0]  status
);
    import hrsp_pkg::*;

    logic err_status;

    assign err_status = (status == StBadHeader) || (status == StFrameChanged)
                        || (status == StSeqBackwards);

    // a stalled beat stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= StSeqBackwards)
        else $error("status code out of range");

    a_err_no_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && err_status |-> !lead_hit && relative_sync == 32'd0)
        else $error("error record carries lead_hit or sync");

    // halt: once an error beat is taken nothing else comes out
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && err_status |=> !out_valid)
        else $error("result after halting error");

endmodule

bind hit_record_stream_parser_unit hrsp_checker u_hrsp_checker (.*);
`default_nettype wire

FILE: tb/tb_hit_record_stream_parser_unit.sv
`default_nettype none
module tb_hit_record_stream_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hrsp_pkg::*;

    localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
    localparam int SettleCycles = 8;
    localparam int HoldCycles   = 160;
    localparam int CycleLimit   = 200000;
    localparam int PhaseHits    = 4;

    typedef struct packed {
        logic [7:0]  header;
        logic [31:0] seq;
        logic [7:0]  frame;
        logic [15:0] sync;
        logic [15:0] target;
        logic [7:0]  die;
        logic [31:0] stamp;
        logic [15:0] cnt_a;
        logic [15:0] cnt_b;
        logic [15:0] cnt_c;
        logic [15:0] cnt_d;
    } hit_rec_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          raw_byte = 8'd0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                lead_hit;
    logic [15:0]         target_id;
    logic [7:0]          die_number;
    logic [31:0]         seq_number;
    logic [7:0]          frame_number;
    logic [31:0]         relative_sync;
    logic [31:0]         time_stamp;
    logic [15:0]         cell_count_a;
    logic [15:0]         cell_count_b;
    logic [15:0]         cell_count_c;
    logic [15:0]         cell_count_d;
    logic [2:0]          status;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [7:0]          cfg_data = 8'd0;

    // decoder copy: configuration and tracking state
    logic        cfg_coinc = 1'b0;
    logic [7:0]  cfg_first = 8'd1;
    logic [7:0]  cfg_next = 8'd2;
    int          pos = 0;
    logic [7:0]  rec [RecBytes] = '{default: 8'd0};
    logic [7:0]  hdr = 8'd0;
    logic [31:0] last_seq = 32'd0;
    logic [7:0]  last_frame = 8'd0;
    logic [31:0] last_sync = 32'd0;
    logic [15:0] wraps = 16'd0;
    logic [15:0] base_sync = 16'd0;
    logic        seen = 1'b0;
    logic        stopped = 1'b0;

    result_t     hits_due [$];
    result_t     oldest_hit;

    logic        no_gaps = 1'b0;
    logic        hold_ask = 1'b0;
    int          hold_left = 0;
    int          cycles = 0;
    int          fails = 0;
    int          bytes_sent = 0;
    int          bytes_dropped = 0;
    int          hits_checked = 0;
    int          input_stall_cycles = 0;
    status_t     halt_cause = StOk;

    hit_record_stream_parser_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .raw_byte       (raw_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lead_hit       (lead_hit),
        .target_id      (target_id),
        .die_number     (die_number),
        .seq_number     (seq_number),
        .frame_number   (frame_number),
        .relative_sync  (relative_sync),
        .time_stamp     (time_stamp),
        .cell_count_a   (cell_count_a),
        .cell_count_b   (cell_count_b),
        .cell_count_c   (cell_count_c),
        .cell_count_d   (cell_count_d),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CycleLimit)
        begin
            $display("%0t: timeout with %0d hits outstanding", $time, hits_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_ask)
        begin
            hold_ask <= 1'b0;
            hold_left = HoldCycles;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_gaps && ($urandom_range(99) < 6);
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        if (in_valid && in_stall)
            input_stall_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (hits_due.size() == 0)
            begin
                $display("%0t: hit with none expected, expected nothing, actual target %0h seq %0h",
                         $time, target_id, seq_number);
                fails++;
            end
            else
            begin
                oldest_hit = hits_due.pop_front();
                check_field("lead_hit", oldest_hit.lead_hit, lead_hit);
                check_field("target_id", oldest_hit.target_id, target_id);
                check_field("die_number", oldest_hit.die_number, die_number);
                check_field("seq_number", oldest_hit.seq_number, seq_number);
                check_field("frame_number", oldest_hit.frame_number, frame_number);
                check_field("relative_sync", oldest_hit.relative_sync, relative_sync);
                check_field("time_stamp", oldest_hit.time_stamp, time_stamp);
                check_field("cell_count_a", oldest_hit.cell_count_a, cell_count_a);
                check_field("cell_count_b", oldest_hit.cell_count_b, cell_count_b);
                check_field("cell_count_c", oldest_hit.cell_count_c, cell_count_c);
                check_field("cell_count_d", oldest_hit.cell_count_d, cell_count_d);
                check_field("status", oldest_hit.status, status);
                hits_checked++;
            end
        end
    end

    task automatic decode_record();
        result_t     r;
        logic [31:0] seq;
        logic [7:0]  frame;
        logic [31:0] sync16;
        logic [31:0] sync;
        logic [31:0] ca, cb, cc, cd;
        status_t     st;
        logic        opens;
        seq    = {rec[3], rec[2], rec[1], rec[0]};
        frame  = rec[4];
        sync16 = {16'd0, rec[6], rec[5]};
        ca     = {16'd0, rec[15], rec[14]};
        cb     = {16'd0, rec[17], rec[16]};
        cc     = {16'd0, rec[19], rec[18]};
        cd     = {16'd0, rec[21], rec[20]};
        st     = StOk;
        opens  = 1'b0;
        sync   = 32'd0;
        // the first record is its own reference
        if (!seen)
        begin
            last_seq   = seq;
            last_frame = frame;
            last_sync  = sync16;
            base_sync  = sync16[15:0];
            wraps      = 16'd0;
        end
        if (cfg_coinc && hdr != cfg_first && hdr != cfg_next)
            st = StBadHeader;
        else if (seq == last_seq && frame != last_frame)
            st = StFrameChanged;
        else if (seq < last_seq)
            st = StSeqBackwards;
        if (st != StOk)
            stopped = 1'b1;
        else
        begin
            sync = sync16 + {wraps, 16'd0};
            if (sync < last_sync)
            begin
                wraps = wraps + 16'd1;
                sync  = sync + 32'h0001_0000;
            end
            if (cfg_coinc)
                opens = (hdr == cfg_first) || !seen;
            else
                opens = (seq != last_seq) || !seen;
            last_seq   = seq;
            last_frame = frame;
            last_sync  = sync;
            seen       = 1'b1;
            if (ca + cb + cc + cd == 32'd0)
                st = StZeroAmp;
            sync = sync - {16'd0, base_sync} + 32'd1;
        end
        r.lead_hit       = opens;
        r.target_id      = {rec[8], rec[7]};
        r.die_number     = rec[9];
        r.seq_number     = seq;
        r.frame_number   = frame;
        r.relative_sync  = sync;
        r.time_stamp     = {rec[13], rec[12], rec[11], rec[10]};
        r.cell_count_a   = ca[15:0];
        r.cell_count_b   = cb[15:0];
        r.cell_count_c   = cc[15:0];
        r.cell_count_d   = cd[15:0];
        r.status         = st;
        hits_due.push_back(r);
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int len;
        len = cfg_coinc ? RecBytes + 1 : RecBytes;
        if (stopped)
        begin
            bytes_dropped++;
            return;
        end
        if (cfg_coinc)
        begin
            if (pos == 0)
                hdr = b;
            else if (pos - 1 < RecBytes)
                rec[pos-1] = b;
        end
        else if (pos < RecBytes)
            rec[pos] = b;
        if (pos + 1 >= len)
        begin
            pos = 0;
            decode_record();
        end
        else
            pos++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (!no_gaps && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        absorb_byte(b);
    endtask

    task automatic send_hit(input hit_rec_t h);
        logic [175:0] flat;
        flat = {h.cnt_d, h.cnt_c, h.cnt_b, h.cnt_a, h.stamp, h.die, h.target, h.sync,
                h.frame, h.seq};
        if (cfg_coinc)
            send_byte(h.header);
        for (int i = 0; i < RecBytes; i++)
            send_byte(flat[8*i +: 8]);
    endtask

    // well-formed hit: sequence never goes back, frame kept within a sequence
    task automatic make_hit(output hit_rec_t h);
        logic [31:0] step;
        step    = ($urandom_range(5) == 0) ? $urandom_range(32'h00FF_FFFF, 1)
                                           : $urandom_range(3, 1);
        h.seq   = last_seq;
        h.frame = last_frame;
        if (!seen)
        begin
            h.seq   = $urandom_range(32'h0FFF_FFFF);
            h.frame = 8'($urandom);
        end
        else if ($urandom_range(4) < 2 && last_seq <= 32'hFFFF_FFFF - step)
        begin
            h.seq   = last_seq + step;
            h.frame = 8'($urandom);
        end
        if (h.seq != last_seq || !seen)
            h.header = ($urandom_range(3) == 0) ? cfg_next : cfg_first;
        else
            h.header = ($urandom_range(3) == 0) ? cfg_first : cfg_next;
        h.sync   = ($urandom_range(7) == 0) ? 16'($urandom)
                                            : 16'(last_sync[15:0] + $urandom_range(16000));
        h.target = 16'($urandom);
        h.die    = 8'($urandom);
        h.stamp  = $urandom;
        case ($urandom_range(9))
            0: {h.cnt_a, h.cnt_b, h.cnt_c, h.cnt_d} = '0;
            1: {h.cnt_a, h.cnt_b, h.cnt_c, h.cnt_d} = '1;
            default:
            begin
                h.cnt_a = 16'($urandom);
                h.cnt_b = 16'($urandom);
                h.cnt_c = 16'($urandom);
                h.cnt_d = 16'($urandom);
            end
        endcase
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (hits_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic configure(input logic coinc, input logic [7:0] first_code,
                             input logic [7:0] next_code);
        logic [CfgIdxW-1:0] regs [4];
        logic [7:0]         vals [4];
        drain_results();
        regs = '{CfgCoincMode, CfgFirstCode, CfgNextCode, CfgSpare};
        vals = '{{7'd0, coinc}, first_code, next_code, 8'($urandom)};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (regs[i])
                CfgCoincMode: cfg_coinc = vals[i][0];
                CfgFirstCode: cfg_first = vals[i];
                CfgNextCode:  cfg_next  = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_first_record();
        hit_rec_t h;
        make_hit(h);
        h.seq    = 32'd0;
        h.frame  = 8'd0;
        h.sync   = 16'hFFFF;
        h.target = 16'd0;
        h.die    = 8'd0;
        h.stamp  = 32'd0;
        {h.cnt_a, h.cnt_b, h.cnt_c, h.cnt_d} = {16'd1, 48'd0};
        send_hit(h);
    endtask

    task automatic test_zero_amplitude();
        hit_rec_t h;
        make_hit(h);
        // same sequence, sync drops to zero: rollover as well
        h.seq   = 32'd0;
        h.frame = 8'd0;
        h.sync  = 16'd0;
        {h.cnt_a, h.cnt_b, h.cnt_c, h.cnt_d} = '0;
        send_hit(h);
    endtask

    task automatic test_field_extremes();
        hit_rec_t h;
        make_hit(h);
        h.seq    = 32'd1;
        h.frame  = 8'hFF;
        h.sync   = 16'h7FFF;
        h.target = 16'hFFFF;
        h.die    = 8'hFF;
        h.stamp  = 32'hFFFF_FFFF;
        {h.cnt_a, h.cnt_b, h.cnt_c, h.cnt_d} = '1;
        send_hit(h);
        make_hit(h);
        h.seq   = 32'd1;
        h.frame = 8'hFF;
        h.sync  = 16'h7FFF;
        send_hit(h);
    endtask

    task automatic test_coincidence_headers();
        hit_rec_t h;
        configure(1'b1, 8'h00, 8'hFF);
        make_hit(h);
        {h.header, h.seq, h.frame} = {8'h00, 32'd2, 8'h10};
        send_hit(h);
        make_hit(h);
        {h.header, h.seq, h.frame} = {8'hFF, 32'd2, 8'h10};
        send_hit(h);
        // new sequence behind a follow-up header does not open a coincidence
        make_hit(h);
        {h.header, h.seq, h.frame} = {8'hFF, 32'd3, 8'h20};
        send_hit(h);
        make_hit(h);
        {h.header, h.seq, h.frame} = {8'h00, 32'd3, 8'h20};
        send_hit(h);
    endtask

    task automatic run_phase(input logic coinc, input logic [7:0] first_code,
                             input logic [7:0] next_code, input logic steady);
        hit_rec_t h;
        configure(coinc, first_code, next_code);
        no_gaps <= steady;
        repeat (PhaseHits)
        begin
            make_hit(h);
            send_hit(h);
        end
        no_gaps <= 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [7:0] shared_code;
        shared_code = 8'($urandom);
        run_phase(1'b0, 8'd1, 8'd2, 1'b0);
        run_phase(1'b1, 8'($urandom), 8'($urandom), 1'b0);
        run_phase(1'b1, shared_code, shared_code, 1'b0);
        run_phase(1'b0, 8'($urandom), 8'($urandom), 1'b1);
        run_phase(1'b1, 8'hFF, 8'h00, 1'b0);
    endtask

    task automatic test_output_backpressure();
        hit_rec_t h;
        drain_results();
        hold_ask <= 1'b1;
        no_gaps  <= 1'b1;
        repeat (5)
        begin
            make_hit(h);
            send_hit(h);
        end
        no_gaps <= 1'b0;
        drain_results();
    endtask

    task automatic test_sequence_top();
        hit_rec_t h;
        make_hit(h);
        h.seq = 32'hFFFF_FFFF;
        if (last_seq == 32'hFFFF_FFFF)
            h.frame = last_frame;
        send_hit(h);
        repeat (2)
        begin
            make_hit(h);
            send_hit(h);
        end
    endtask

    task automatic test_halt_on_error();
        hit_rec_t h;
        status_t  causes [3];
        causes     = '{StBadHeader, StFrameChanged, StSeqBackwards};
        halt_cause = causes[$urandom_range(2)];
        if (halt_cause == StBadHeader)
            configure(1'b1, 8'h3C, 8'hC3);
        make_hit(h);
        case (halt_cause)
            StBadHeader:
                do
                    h.header = 8'($urandom);
                while (h.header == cfg_first || h.header == cfg_next);
            StFrameChanged:
            begin
                h.seq   = last_seq;
                h.frame = last_frame ^ 8'h01;
            end
            default:
                h.seq = last_seq - 32'd1;
        endcase
        send_hit(h);
        // halted: everything after this is dropped
        repeat (40)
            send_byte(8'($urandom));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_record();
        test_zero_amplitude();
        test_field_extremes();
        test_coincidence_headers();
        test_random_traffic();
        test_output_backpressure();
        test_sequence_top();
        test_halt_on_error();
        drain_results();
        $display("covered %0d stream bytes, %0d decoded hits, plain and coincidence modes",
                 bytes_sent, hits_checked);
        $display("input held back %0d cycles by a full output; halt on %s dropped %0d bytes",
                 input_stall_cycles, halt_cause.name(), bytes_dropped);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/hrsp_pkg.sv
rtl/core/hrsp_decode.sv
rtl/core/hit_record_stream_parser_unit.sv
rtl/core/hrsp_checker.sv
tb/tb_hit_record_stream_parser_unit.sv
